/* design/rti_pkg.sv */
// Shared types, constants and codes of the recorded trace interpolator.
// No dependencies; every other design file imports this package.
package rti_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  // Field widths
  localparam int POS_W   = 40;
  localparam int VAL_W   = 32;
  localparam int RANK_W  = 8;
  localparam int IMG_W   = 16;
  localparam int DELTA_W = 20;
  localparam int OFS_W   = 31;
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 11;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 2;

  // Internal widths
  localparam int ACC_W     = 64;
  localparam int QPOS_W    = 42;
  localparam int DIST_W    = POS_W + 1;
  localparam int REM_W     = POS_W + 2;
  localparam int FRAC_BITS = 30;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int STEP_W    = $clog2(FRAC_BITS + 1);
  localparam int DV_W      = VAL_W + 1;
  localparam int IMGPOS_W  = IMG_W + DELTA_W;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_DELTA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_ENCODER     = 2'd2;

  // Register reset values
  localparam logic [DELTA_W-1:0] TRIGGER_DELTA_RST = 20'd100000;
  localparam logic [OFS_W-1:0]   POSITION_OFFSET_RST = '0;
  localparam logic               USE_ENCODER_RST = 1'b0;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos;
    logic signed [VAL_W-1:0]  val;
    logic        [RANK_W-1:0] rank;
  } entry_t;

  // Operands for the shared adder
  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QPOS,
    ST_SCAN,
    ST_DIFF_D,
    ST_DIFF_N,
    ST_DIV,
    ST_DVAL,
    ST_MUL,
    ST_ROUND,
    ST_FINAL
  } state_t;

endpackage

/* design/rti_alu.sv */
// Shared 64-bit add/subtract unit of the interpolator.
// Depends on rti_pkg (alu_req_t, ACC_W).
module rti_alu
  import rti_pkg::*;
(
  input  alu_req_t         req,
  output logic [ACC_W-1:0] sum
);

  logic [ACC_W-1:0] b_eff;

  assign b_eff = req.sub ? ~req.b : req.b;
  assign sum   = req.a + b_eff + ACC_W'(req.sub);

endmodule

/* design/rti_table.sv */
// Trace table memory: one write port, one registered read port.
// Depends on rti_pkg (entry_t).
module rti_table
  import rti_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/rti_seq.sv */
// Sequencer and datapath registers: table scan, serial divide and multiply.
// Depends on rti_pkg; drives rti_table and the shared rti_alu.
module rti_seq
  import rti_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int AW = $clog2(TABLE_DEPTH),
  parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [KIND_W-1:0]         kind,
  input  logic signed [POS_W-1:0]   entry_position,
  input  logic signed [VAL_W-1:0]   entry_value,
  input  logic [RANK_W-1:0]         entry_rank,
  input  logic [IMG_W-1:0]          image_number,
  input  logic signed [POS_W-1:0]   encoder_position,
  input  logic [DELTA_W-1:0]        trigger_delta,
  input  logic signed [OFS_W-1:0]   position_offset,
  input  logic                      use_encoder_position,
  output logic                      busy,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output entry_t                    wr_data,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  entry_t                    rd_data,
  output alu_req_t                  alu_req,
  input  logic [ACC_W-1:0]          alu_sum,
  output logic                      done,
  output logic                      found,
  output logic signed [VAL_W-1:0]   value,
  output logic [RANK_W-1:0]         rank,
  output logic [CW-1:0]             kidx_out
);

  state_t state, state_next;

  logic [CW-1:0]             count, count_next;
  logic [CW-1:0]             addr, addr_next;
  logic [CW-1:0]             cmp_idx, cmp_idx_next;
  logic                      pend, pend_next;
  logic signed [QPOS_W-1:0]  q, q_next;
  entry_t                    prev, prev_next;
  entry_t                    nxt, nxt_next;
  logic [CW-1:0]             kidx, kidx_next;
  logic [DIST_W-1:0]         d, d_next;
  logic [REM_W-1:0]          r, r_next;
  logic [FRAC_W-1:0]         fq, fq_next;
  logic [STEP_W-1:0]         step, step_next;
  logic signed [DV_W-1:0]    dv, dv_next;
  logic signed [ACC_W-1:0]   acc, acc_next;
  logic                      done_next, found_next;
  logic signed [VAL_W-1:0]   value_next;
  logic [RANK_W-1:0]         rank_next;
  logic [CW-1:0]             kidx_out_next;

  logic [IMGPOS_W-1:0]       img_pos;
  logic [REM_W-1:0]          trial;
  logic                      ge;
  logic [RANK_W-1:0]         min_rank;

  assign img_pos  = image_number * trigger_delta;
  assign trial    = (step == '0) ? r : {r[REM_W-2:0], 1'b0};
  assign ge       = ~alu_sum[ACC_W-1];
  assign min_rank = (prev.rank < nxt.rank) ? prev.rank : nxt.rank;
  assign busy     = (state != ST_IDLE);

  assign wr_addr         = count[AW-1:0];
  assign wr_data.pos     = entry_position;
  assign wr_data.val     = entry_value;
  assign wr_data.rank    = entry_rank;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    addr     <= addr_next;
    cmp_idx  <= cmp_idx_next;
    pend     <= pend_next;
    q        <= q_next;
    prev     <= prev_next;
    nxt      <= nxt_next;
    kidx     <= kidx_next;
    d        <= d_next;
    r        <= r_next;
    fq       <= fq_next;
    step     <= step_next;
    dv       <= dv_next;
    acc      <= acc_next;
    found    <= found_next;
    value    <= value_next;
    rank     <= rank_next;
    kidx_out <= kidx_out_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    addr_next     = addr;
    cmp_idx_next  = cmp_idx;
    pend_next     = pend;
    q_next        = q;
    prev_next     = prev;
    nxt_next      = nxt;
    kidx_next     = kidx;
    d_next        = d;
    r_next        = r;
    fq_next       = fq;
    step_next     = step;
    dv_next       = dv;
    acc_next      = acc;
    done_next     = 1'b0;
    found_next    = found;
    value_next    = value;
    rank_next     = rank;
    kidx_out_next = kidx_out;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = addr[AW-1:0];
    alu_req.a     = '0;
    alu_req.b     = '0;
    alu_req.sub   = 1'b0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          case (kind)
            KIND_CLEAR: begin
              count_next = '0;
            end
            KIND_APPEND: begin
              if (count < CW'(TABLE_DEPTH)) begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
              end
            end
            KIND_QUERY: begin
              acc_next   = use_encoder_position ? ACC_W'(encoder_position)
                                                : ACC_W'(img_pos);
              state_next = ST_QPOS;
            end
            default: ;
          endcase
        end
      end

      ST_QPOS: begin
        alu_req.a  = acc;
        alu_req.b  = ACC_W'(position_offset);
        q_next     = alu_sum[QPOS_W-1:0];
        addr_next  = '0;
        pend_next  = 1'b0;
        state_next = ST_SCAN;
      end

      ST_SCAN: begin
        // Compare the entry read last cycle against the query position
        alu_req.a   = ACC_W'(rd_data.pos);
        alu_req.b   = ACC_W'(q);
        alu_req.sub = 1'b1;
        if (pend && ge) begin
          nxt_next  = rd_data;
          kidx_next = cmp_idx;
          if (cmp_idx == '0) begin
            done_next     = 1'b1;
            found_next    = 1'b1;
            value_next    = rd_data.val;
            rank_next     = rd_data.rank;
            kidx_out_next = cmp_idx;
            state_next    = ST_IDLE;
          end else begin
            state_next = ST_DIFF_D;
          end
        end else if ((pend && (cmp_idx + CW'(1) == count)) || (!pend && addr >= count)) begin
          if (pend) begin
            prev_next = rd_data;
          end
          done_next     = 1'b1;
          found_next    = 1'b0;
          value_next    = '0;
          rank_next     = '0;
          kidx_out_next = count;
          state_next    = ST_IDLE;
        end else begin
          if (pend) begin
            prev_next = rd_data;
          end
          // Keep one read in flight ahead of the compare
          if (addr < count) begin
            rd_en        = 1'b1;
            addr_next    = addr + CW'(1);
            cmp_idx_next = addr;
            pend_next    = 1'b1;
          end else begin
            pend_next = 1'b0;
          end
        end
      end

      ST_DIFF_D: begin
        alu_req.a   = ACC_W'(nxt.pos);
        alu_req.b   = ACC_W'(prev.pos);
        alu_req.sub = 1'b1;
        d_next      = alu_sum[DIST_W-1:0];
        state_next  = ST_DIFF_N;
      end

      ST_DIFF_N: begin
        alu_req.a   = ACC_W'(q);
        alu_req.b   = ACC_W'(prev.pos);
        alu_req.sub = 1'b1;
        r_next      = REM_W'(alu_sum[DIST_W-1:0]);
        step_next   = '0;
        fq_next     = '0;
        state_next  = ST_DIV;
      end

      ST_DIV: begin
        // Restoring divide, one quotient bit per cycle
        alu_req.a   = ACC_W'(trial);
        alu_req.b   = ACC_W'(d);
        alu_req.sub = 1'b1;
        r_next      = ge ? alu_sum[REM_W-1:0] : trial;
        fq_next     = {fq[FRAC_W-2:0], ge};
        if (step == STEP_W'(FRAC_BITS)) begin
          state_next = ST_DVAL;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end

      ST_DVAL: begin
        alu_req.a   = ACC_W'(nxt.val);
        alu_req.b   = ACC_W'(prev.val);
        alu_req.sub = 1'b1;
        dv_next     = alu_sum[DV_W-1:0];
        acc_next    = '0;
        step_next   = '0;
        state_next  = ST_MUL;
      end

      ST_MUL: begin
        // Shift-add multiply, fraction MSB first
        alu_req.a = {acc[ACC_W-2:0], 1'b0};
        alu_req.b = fq[FRAC_W-1] ? ACC_W'(dv) : '0;
        acc_next  = alu_sum;
        fq_next   = {fq[FRAC_W-2:0], 1'b0};
        if (step == STEP_W'(FRAC_BITS)) begin
          state_next = ST_ROUND;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end

      ST_ROUND: begin
        alu_req.a  = acc;
        alu_req.b  = ACC_W'(1) << (FRAC_BITS - 1);
        acc_next   = alu_sum;
        state_next = ST_FINAL;
      end

      ST_FINAL: begin
        alu_req.a     = ACC_W'(prev.val);
        alu_req.b     = acc >>> FRAC_BITS;
        done_next     = 1'b1;
        found_next    = 1'b1;
        value_next    = alu_sum[VAL_W-1:0];
        rank_next     = min_rank;
        kidx_out_next = kidx;
        state_next    = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/recorded_trace_interpolator.sv */
// Recorded trace interpolator: clear, append or query a table of (position, value, rank).
// Clear and append give no result and never raise busy.
// Query: the table is scanned one entry per cycle for the first entry at or above the position;
// entry 0 gives its own value and rank, none gives not found, and entry k > 0 is followed by a
// 31-step divide and a 31-step multiply on the shared adder.
// One item at a time; done cannot be stalled. Reset (rst, sync): empties the trace, restores regs.
module recorded_trace_interpolator
  import rti_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        kind,
  input  logic signed [POS_W-1:0]  entry_position,
  input  logic signed [VAL_W-1:0]  entry_value,
  input  logic [RANK_W-1:0]        entry_rank,
  input  logic [IMG_W-1:0]         image_number,
  input  logic signed [POS_W-1:0]  encoder_position,
  // result channel
  output logic                     done,
  output logic                     found,
  output logic signed [VAL_W-1:0]  value,
  output logic [RANK_W-1:0]        rank,
  output logic [IDX_W-1:0]         entry_index,
  // register write port
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [DELTA_W-1:0]       trigger_delta;
  logic signed [OFS_W-1:0]  position_offset;
  logic                     use_encoder_position;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  alu_req_t      alu_req;
  logic [ACC_W-1:0] alu_sum;
  logic [CW-1:0]    kidx;
  logic [IDX_W+CW-1:0] kidx_wide;

  // Register writes: a transfer lands the same edge; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_delta        <= TRIGGER_DELTA_RST;
      position_offset      <= POSITION_OFFSET_RST;
      use_encoder_position <= USE_ENCODER_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TRIGGER_DELTA:   trigger_delta        <= cfg_data[DELTA_W-1:0];
        CFG_POSITION_OFFSET: position_offset      <= cfg_data[OFS_W-1:0];
        CFG_USE_ENCODER:     use_encoder_position <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Entry index keeps the low bits of the scan position at the port width.
  assign kidx_wide   = (IDX_W + CW)'(kidx);
  assign entry_index = kidx_wide[IDX_W-1:0];

  rti_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared adder: position offset, scan compare, differences, divide steps, multiply
  // accumulate, rounding and the final sum all go through it.
  rti_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  rti_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk                  (clk),
    .rst                  (rst),
    .start                (start),
    .kind                 (kind),
    .entry_position       (entry_position),
    .entry_value          (entry_value),
    .entry_rank           (entry_rank),
    .image_number         (image_number),
    .encoder_position     (encoder_position),
    .trigger_delta        (trigger_delta),
    .position_offset      (position_offset),
    .use_encoder_position (use_encoder_position),
    .busy                 (busy),
    .wr_en                (wr_en),
    .wr_addr              (wr_addr),
    .wr_data              (wr_data),
    .rd_en                (rd_en),
    .rd_addr              (rd_addr),
    .rd_data              (rd_data),
    .alu_req              (alu_req),
    .alu_sum              (alu_sum),
    .done                 (done),
    .found                (found),
    .value                (value),
    .rank                 (rank),
    .kidx_out             (kidx)
  );

endmodule

/* design/rti_checker.sv */
// Port-level checker for the recorded trace interpolator, bound to the top.
// Depends on rti_pkg and recorded_trace_interpolator.
module rti_checker
  import rti_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic [KIND_W-1:0]       kind,
  input logic                    done,
  input logic                    found,
  input logic signed [VAL_W-1:0] value,
  input logic [RANK_W-1:0]       rank
);

  // A query transfer keeps the block busy on the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_QUERY) |=> busy)
    else $error("query transfer did not raise busy");

  // Clear, append and unused kinds finish at once with no result.
  a_cmd_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind != KIND_QUERY) |=> (!busy && !done))
    else $error("non-query transfer raised busy or a result");

  // A result follows a busy cycle and leaves the block ready.
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a query");

  // A not-found result carries zero value and rank.
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (value == '0 && rank == '0))
    else $error("not-found result with nonzero payload");

endmodule

bind recorded_trace_interpolator rti_checker u_rti_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .kind  (kind),
  .done  (done),
  .found (found),
  .value (value),
  .rank  (rank)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for recorded_trace_interpolator: directed table, random traces, full trace.
// Depends on rti_pkg (widths, item kinds, register indexes) and the design top level.
module tb;
  import rti_pkg::*;

  localparam int TRACE_DEPTH = 1024;
  localparam int FRAC = 30;
  localparam int ITEMS_GOAL = 500;
  localparam int SETTLE = 4;           // clear and append finish without raising busy
  localparam int TAIL_CYCLES = 1200;   // outlasts the longest query on a full trace
  localparam int LIMIT = 4000000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // One command transfer, every field on its own port
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] val;
    logic [RANK_W-1:0]       rnk;
    logic [IMG_W-1:0]        img;
    logic signed [POS_W-1:0] enc;
  } trace_cmd_t;

  // One lookup result, as seen on the result ports
  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] value;
    logic [RANK_W-1:0]       rank;
    logic [IDX_W-1:0]        entry_index;
  } lookup_t;

  // Directed row: either a register write or a command, optionally with a typed-in result
  typedef struct packed {
    logic                 is_write;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     reg_data;
    trace_cmd_t           cmd;
    logic                 typed;
    lookup_t              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [KIND_W-1:0] kind;
  logic signed [POS_W-1:0] entry_position;
  logic signed [VAL_W-1:0] entry_value;
  logic [RANK_W-1:0] entry_rank;
  logic [IMG_W-1:0] image_number;
  logic signed [POS_W-1:0] encoder_position;
  logic done;
  logic found;
  logic signed [VAL_W-1:0] value;
  logic [RANK_W-1:0] rank;
  logic [IDX_W-1:0] entry_index;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  recorded_trace_interpolator dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .kind(kind),
    .entry_position(entry_position), .entry_value(entry_value), .entry_rank(entry_rank),
    .image_number(image_number), .encoder_position(encoder_position),
    .done(done), .found(found), .value(value), .rank(rank), .entry_index(entry_index),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the trace and the registers
  longint                  trace_pos [TRACE_DEPTH];
  logic signed [VAL_W-1:0] trace_val [TRACE_DEPTH];
  logic [RANK_W-1:0]       trace_rank [TRACE_DEPTH];
  int                      trace_len = 0;
  logic [DELTA_W-1:0]      model_delta = 20'd100000;
  logic signed [OFS_W-1:0] model_offset = '0;
  logic                    model_encoder = 1'b0;

  lookup_t   expected_lookups[$];
  stim_row_t rows[$];
  int        items_sent = 0;
  int        fail_count = 0;
  int        cycle_count = 0;
  logic      idle_on = 1'b1;
  lookup_t   head;

  function automatic longint pos_to_long(logic [POS_W-1:0] p);
    return longint'(signed'(p));
  endfunction

  // Uniform draw in [lo, hi]; span must stay positive
  function automatic longint rand_between(longint lo, longint hi);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return lo + longint'(r % 64'(hi - lo + 1));
  endfunction

  function automatic trace_cmd_t random_cmd();
    trace_cmd_t c;
    c.kind = KIND_W'($urandom_range(0, 3));
    c.pos  = POS_W'({$urandom, $urandom});
    c.val  = VAL_W'($urandom);
    c.rnk  = RANK_W'($urandom);
    c.img  = IMG_W'($urandom);
    c.enc  = POS_W'({$urandom, $urandom});
    return c;
  endfunction

  // Form the query position, scan for the first entry at or above it and
  // interpolate between it and its predecessor (fraction in Q1.30, round half up).
  function automatic lookup_t interpolate_query(trace_cmd_t c);
    longint qpos, n, d, dv, prod, frac;
    logic [127:0] num, quot;
    int k;
    lookup_t r;
    r = '0;
    if (model_encoder)
      qpos = pos_to_long(c.enc);
    else
      qpos = longint'(c.img) * longint'(model_delta);
    qpos = qpos + longint'(model_offset);
    k = 0;
    while (k < trace_len && trace_pos[k] < qpos) k++;
    r.entry_index = IDX_W'(k);
    if (k >= trace_len) return r;
    r.found = 1'b1;
    // First entry: both neighbours are entry 0, whatever its position
    if (k == 0) begin
      r.value = trace_val[0];
      r.rank  = trace_rank[0];
      return r;
    end
    n = qpos - trace_pos[k-1];
    d = trace_pos[k] - trace_pos[k-1];
    num = {64'd0, n} << FRAC;
    quot = num / {64'd0, d};
    frac = longint'(quot[63:0]);
    dv = longint'(trace_val[k]) - longint'(trace_val[k-1]);
    prod = dv * frac + (longint'(1) <<< (FRAC - 1));
    r.value = VAL_W'(longint'(trace_val[k-1]) + (prod >>> FRAC));
    r.rank = (trace_rank[k-1] < trace_rank[k]) ? trace_rank[k-1] : trace_rank[k];
    return r;
  endfunction

  // Apply one accepted command to the shadow trace; queue the result of a query
  function automatic void track_item(trace_cmd_t c);
    case (c.kind)
      KIND_CLEAR: trace_len = 0;
      KIND_APPEND: begin
        // a full trace drops further appends
        if (trace_len < TRACE_DEPTH) begin
          trace_pos[trace_len]  = pos_to_long(c.pos);
          trace_val[trace_len]  = c.val;
          trace_rank[trace_len] = c.rnk;
          trace_len++;
        end
      end
      KIND_QUERY: expected_lookups.push_back(interpolate_query(c));
      default: ;
    endcase
  endfunction

  // Hold off for a random gap, present the command and wait for the transfer.
  // Start stays high after the transfer; the caller's next step lands on the next falling edge.
  task automatic send_item(input trace_cmd_t c, input logic typed, input lookup_t want);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind = c.kind;
    entry_position = c.pos;
    entry_value = c.val;
    entry_rank = c.rnk;
    image_number = c.img;
    encoder_position = c.enc;
    start = 1'b1;
    do @(posedge clk); while (busy);
    if (c.kind != KIND_UNUSED) items_sent++;
    if (typed)
      expected_lookups.push_back(want);
    else
      track_item(c);
  endtask

  // Drop start and wait until every queued result is back and the block is idle
  task automatic wait_for_results();
    @(negedge clk);
    start = 1'b0;
    while (expected_lookups.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_for_results();
    cfg_index = idx;
    cfg_data = data;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_TRIGGER_DELTA:   model_delta = data[DELTA_W-1:0];
      CFG_POSITION_OFFSET: model_offset = signed'(data[OFS_W-1:0]);
      CFG_USE_ENCODER:     model_encoder = data[0];
      default: ;
    endcase
  endtask

  function automatic stim_row_t item_row(logic [KIND_W-1:0] k, logic signed [POS_W-1:0] p,
                                         logic signed [VAL_W-1:0] v, logic [RANK_W-1:0] r,
                                         logic [IMG_W-1:0] i, logic signed [POS_W-1:0] e);
    stim_row_t row;
    row = '0;
    row.cmd.kind = k;
    row.cmd.pos = p;
    row.cmd.val = v;
    row.cmd.rnk = r;
    row.cmd.img = i;
    row.cmd.enc = e;
    return row;
  endfunction

  function automatic stim_row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_index = idx;
    row.reg_data = data;
    return row;
  endfunction

  // Attach a typed-in result to the last row
  function automatic void typed_last(logic f, logic signed [VAL_W-1:0] v, logic [RANK_W-1:0] r,
                                     logic [IDX_W-1:0] x);
    rows[rows.size()-1].typed = 1'b1;
    rows[rows.size()-1].want = '{f, v, r, x};
  endfunction

  // One random trace: mostly clear, a run of appends around a reachable region
  // and queries near it; sometimes a burst of unconstrained noise instead.
  task automatic random_trace_burst();
    int n_entries, img0, i;
    longint lo, hi, span, pos, jit, q;
    int step_bits;
    trace_cmd_t c;
    idle_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 9) == 0) wait_for_results();
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 8)) send_item(random_cmd(), 1'b0, '0);
      return;
    end
    if (trace_len > 200 || $urandom_range(0, 4) != 0) begin
      c = random_cmd();
      c.kind = KIND_CLEAR;
      send_item(c, 1'b0, '0);
    end
    n_entries = $urandom_range(1, 24);
    img0 = $urandom_range(2, 65535 - 30);
    lo = rand_between(-(longint'(1) <<< 38), longint'(1) <<< 38);
    step_bits = $urandom_range(0, 30);
    jit = longint'(model_delta) / 2 + 2;
    pos = lo;
    for (i = 0; i < n_entries; i++) begin
      c = random_cmd();
      c.kind = KIND_APPEND;
      if (model_encoder) begin
        c.pos = POS_W'(pos);
        // repeat a position now and then
        if ($urandom_range(0, 7) != 0) pos = pos + rand_between(1, longint'(1) <<< step_bits);
      end else begin
        c.pos = POS_W'(longint'(img0 + i) * longint'(model_delta) + longint'(model_offset)
                       + rand_between(-jit, jit));
      end
      send_item(c, 1'b0, '0);
    end
    hi = pos;
    span = hi - lo;
    repeat ($urandom_range(1, 10)) begin
      c = random_cmd();
      c.kind = KIND_QUERY;
      if ($urandom_range(0, 3) == 0 && trace_len > 0)
        q = trace_pos[$urandom_range(0, trace_len - 1)];
      else
        q = rand_between(lo - span / 4 - 1, hi + span / 4 + 1);
      c.enc = POS_W'(q - longint'(model_offset));
      c.img = IMG_W'($urandom_range(img0 - 2, img0 + n_entries + 2));
      send_item(c, 1'b0, '0);
    end
  endtask

  // Check each result strobe against the oldest expected lookup
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_lookups.size() == 0) begin
        $error("result with no query outstanding: found %0d value %0d index %0d",
               found, value, entry_index);
        fail_count++;
      end else begin
        head = expected_lookups.pop_front();
        if (found !== head.found) begin
          $error("found: expected %0d, got %0d", head.found, found);
          fail_count++;
        end
        if (value !== head.value) begin
          $error("value: expected %0d, got %0d", $signed(head.value), value);
          fail_count++;
        end
        if (rank !== head.rank) begin
          $error("rank: expected %0d, got %0d", head.rank, rank);
          fail_count++;
        end
        if (entry_index !== head.entry_index) begin
          $error("entry_index: expected %0d, got %0d", head.entry_index, entry_index);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int phase, phase_start, i, j;
    logic [CFG_W-1:0] delta_data, offset_data;
    logic enc_bit;
    longint probe;
    trace_cmd_t c;

    rst = 1'b1;
    start = 1'b0;
    kind = KIND_CLEAR;
    entry_position = '0;
    entry_value = '0;
    entry_rank = '0;
    image_number = '0;
    encoder_position = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_TRIGGER_DELTA;
    cfg_data = '0;

    // Directed table; registers start at delta 100000, offset 0, image based
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 16'd0, 0));          // empty trace
    typed_last(1'b0, 0, 0, 11'd0);
    rows.push_back(item_row(KIND_APPEND, 40'sd100000, 32'sh7FFF_FFFF, 8'd255, 0, 0));
    rows.push_back(item_row(KIND_APPEND, 40'sd300000, 32'sh8000_0000, 8'd0, 0, 0));
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 16'd0, 0));          // below entry 0
    typed_last(1'b1, 32'sh7FFF_FFFF, 8'd255, 11'd0);
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 16'd1, 0));          // exactly on entry 0
    typed_last(1'b1, 32'sh7FFF_FFFF, 8'd255, 11'd0);
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 16'd3, 0));          // exactly on entry 1
    typed_last(1'b1, 32'sh8000_0000, 8'd0, 11'd1);
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 16'd2, 0));          // midpoint, full swing
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 16'd4, 0));          // past the end
    typed_last(1'b0, 0, 0, 11'd2);
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 16'hFFFF, 0));
    typed_last(1'b0, 0, 0, 11'd2);
    rows.push_back(item_row(KIND_APPEND, 40'sh80_0000_0000, 0, 8'd7, 0, 0));
    rows.push_back(item_row(KIND_APPEND, 40'sh7F_FFFF_FFFF, -32'sd1, 8'd200, 0, 0));
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 16'hFFFF, 0));       // widest interval
    rows.push_back(item_row(KIND_UNUSED, -40'sd1, -32'sd1, 8'hFF, 16'hFFFF, -40'sd1));
    rows.push_back(item_row(KIND_CLEAR, 0, 0, 0, 0, 0));
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 16'd5, 0));          // cleared trace
    typed_last(1'b0, 0, 0, 11'd0);
    rows.push_back(item_row(KIND_APPEND, 40'sd500000, 32'sd5, 8'd3, 0, 0));
    rows.push_back(item_row(KIND_APPEND, 40'sd500000, 32'sd9, 8'd4, 0, 0));  // equal position
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 16'd5, 0));
    typed_last(1'b1, 32'sd5, 8'd3, 11'd0);
    rows.push_back(write_row(CFG_TRIGGER_DELTA, '0));                  // image position is zero
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 16'hFFFF, 0));
    typed_last(1'b1, 32'sd5, 8'd3, 11'd0);
    rows.push_back(write_row(CFG_USE_ENCODER, CFG_W'(1)));
    rows.push_back(write_row(CFG_POSITION_OFFSET, 31'h4000_0000));     // most negative offset
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 0, 40'sh7F_FFFF_FFFF));
    typed_last(1'b0, 0, 0, 11'd2);
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 0, 40'sh80_0000_0000));
    typed_last(1'b1, 32'sd5, 8'd3, 11'd0);
    rows.push_back(write_row(CFG_POSITION_OFFSET, 31'h3FFF_FFFF));     // most positive offset
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 0, 40'sd0));
    typed_last(1'b0, 0, 0, 11'd2);
    rows.push_back(item_row(KIND_APPEND, 40'sd1073741825, -32'sd7, 8'd1, 0, 0));
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 0, 40'sd1));         // behind an equal pair
    rows.push_back(item_row(KIND_QUERY, 0, 0, 0, 0, 40'sd2));
    typed_last(1'b1, -32'sd7, 8'd1, 11'd2);

    // Hold reset, then release it between edges
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      if (rows[i].is_write)
        write_reg(rows[i].reg_index, rows[i].reg_data);
      else
        send_item(rows[i].cmd, rows[i].typed, rows[i].want);
    end

    // Random traces under a run of register settings, extremes first
    for (phase = 0; items_sent < ITEMS_GOAL; phase++) begin
      delta_data = CFG_W'($urandom);
      offset_data = CFG_W'($urandom);
      enc_bit = 1'($urandom_range(0, 1));
      case (phase)
        0: begin delta_data = CFG_W'(20'hFFFFF); offset_data = '0; enc_bit = 1'b0; end
        1: begin delta_data = CFG_W'(1); offset_data = 31'h4000_0000; enc_bit = 1'b0; end
        2: begin offset_data = 31'h3FFF_FFFF; enc_bit = 1'b1; end
        3: begin offset_data = 31'h4000_0000; enc_bit = 1'b1; end
        4: begin delta_data = '0; enc_bit = 1'b0; end
        default: ;
      endcase
      write_reg(CFG_TRIGGER_DELTA, delta_data);
      write_reg(CFG_POSITION_OFFSET, offset_data);
      write_reg(CFG_USE_ENCODER, CFG_W'(enc_bit));
      phase_start = items_sent;
      while (items_sent - phase_start < 60) random_trace_burst();
    end

    // Fill the trace to the top, push two appends that must be dropped, then probe it
    write_reg(CFG_USE_ENCODER, CFG_W'(1));
    write_reg(CFG_POSITION_OFFSET, '0);
    idle_on = 1'b1;
    c = random_cmd();
    c.kind = KIND_CLEAR;
    send_item(c, 1'b0, '0);
    for (i = 0; i < TRACE_DEPTH + 2; i++) begin
      c = random_cmd();
      c.kind = KIND_APPEND;
      c.pos = POS_W'(longint'(i) * 1000 + longint'($urandom_range(0, 999)));
      send_item(c, 1'b0, '0);
    end
    for (j = 0; j < 6; j++) begin
      case (j)
        0: probe = -1;
        1: probe = 511500;
        2: probe = 1023000;
        3: probe = 1030000;      // beyond the last entry
        default: probe = rand_between(0, 1024000);
      endcase
      c = random_cmd();
      c.kind = KIND_QUERY;
      c.enc = POS_W'(probe);
      send_item(c, 1'b0, '0);
    end

    // Drain, then give any stray result time to show up
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
